FILE: src/bpc_pkg.sv
// Shared types, register indexes and arithmetic constants for the barometric
// pressure compensation core. No dependencies; every other file imports this package.
package bpc_pkg;

  // Input beat: one raw pressure count (D1) and one raw temperature count (D2).
  typedef struct packed {
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;
  } in_t;

  // Result beat: compensated temperature (0.01 C) and pressure (Pa).
  typedef struct packed {
    logic signed [31:0] temperature;
    logic signed [31:0] pressure;
  } out_t;

  // Factory calibration words C1..C6.
  typedef struct packed {
    logic [15:0] sens_coef;
    logic [15:0] off_coef;
    logic [15:0] sens_temp_coef;
    logic [15:0] off_temp_coef;
    logic [15:0] ref_temp;
    logic [15:0] temp_slope;
  } cal_t;

  localparam int unsigned REG_INDEX_W = 3;
  localparam int unsigned REG_DATA_W  = 16;

  localparam logic [REG_INDEX_W-1:0] REG_SENS_COEF      = 3'd0;
  localparam logic [REG_INDEX_W-1:0] REG_OFF_COEF       = 3'd1;
  localparam logic [REG_INDEX_W-1:0] REG_SENS_TEMP_COEF = 3'd2;
  localparam logic [REG_INDEX_W-1:0] REG_OFF_TEMP_COEF  = 3'd3;
  localparam logic [REG_INDEX_W-1:0] REG_REF_TEMP       = 3'd4;
  localparam logic [REG_INDEX_W-1:0] REG_TEMP_SLOPE     = 3'd5;

  // Temperature break points, expressed relative to the 20.00 C base.
  localparam int TEMP_BASE      = 2000;
  localparam int VERY_LOW_DELTA = 3500;   // -15.00 C is 3500 below the base

  // Cycles from an accepted input beat to its result strobe.
  localparam int unsigned LATENCY = 11;

  // Clamp a 33-bit signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v > 33'sd2147483647) begin
      r = 32'sh7fff_ffff;
    end else if (v < -33'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: src/bpc_cal_regs.sv
// Calibration register file: six 16-bit words loaded through the write port.
// Depends on bpc_pkg for cal_t and the register index constants.
module bpc_cal_regs
  import bpc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [REG_INDEX_W-1:0] wr_index,
  input  logic [REG_DATA_W-1:0]  wr_data,
  output cal_t                   cal
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_SENS_COEF:      cal.sens_coef      <= wr_data;
        REG_OFF_COEF:       cal.off_coef       <= wr_data;
        REG_SENS_TEMP_COEF: cal.sens_temp_coef <= wr_data;
        REG_OFF_TEMP_COEF:  cal.off_temp_coef  <= wr_data;
        REG_REF_TEMP:       cal.ref_temp       <= wr_data;
        REG_TEMP_SLOPE:     cal.temp_slope     <= wr_data;
        default: begin
          // Indexes past the last register are ignored.
        end
      endcase
    end
  end

endmodule

FILE: src/barometric_pressure_compensation_core.sv
// Top level of the barometric pressure compensation core: an eleven-stage pipeline.
// Depends on bpc_pkg and bpc_cal_regs.
//
//   Channel   Ports                           Handshake
//   --------  ------------------------------  ---------------------------------
//   input     start, busy, sample             beat taken when start && !busy
//   result    done, result                    beat valid for the one cycle done
//   config    wr_en, wr_index, wr_data        write taken when wr_en is high
//
// One beat can enter every cycle outside reset; results leave in the order their
// beats were taken. The latency is set by the chain of multiplies: the
// calibration products, the squares for the second-order terms and the wide
// pressure product, which is split into two partial products over two stages.
// Reset is synchronous and clears every valid bit and the calibration words;
// busy is high only while reset is held. The receiver cannot stall, so nothing
// in the pipeline ever waits.
module barometric_pressure_compensation_core
  import bpc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  in_t                    sample,
  output logic                   done,
  output out_t                   result,
  input  logic                   wr_en,
  input  logic [REG_INDEX_W-1:0] wr_index,
  input  logic [REG_DATA_W-1:0]  wr_data
);

  cal_t cal;

  bpc_cal_regs u_cal_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cal      (cal)
  );

  // The pipeline never back-pressures; only reset keeps a beat out.
  assign busy = rst;

  logic accept;
  assign accept = start && !busy;

  // One valid bit per stage travels with the data.
  logic [LATENCY-1:0] valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[LATENCY-2:0], accept};
    end
  end

  assign done = valid[LATENCY-1];

  // Stage 1: capture the raw counts.
  logic [23:0] s1_d1;
  logic [23:0] s1_d2;

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_d1 <= sample.raw_pressure;
      s1_d2 <= sample.raw_temperature;
    end
  end

  // Stage 2: signed temperature difference dT = D2 - C5 * 256. The difference
  // is kept signed, so a reading below the reference goes negative.
  logic [23:0]        s2_d1;
  logic signed [24:0] s2_dt;

  always_ff @(posedge clk) begin
    s2_d1 <= s1_d1;
    s2_dt <= $signed({1'b0, s1_d2}) - $signed({1'b0, cal.ref_temp, 8'd0});
  end

  // Stage 3: the four products on dT, each one multiplier of at most 25x25 bits.
  logic [23:0]        s3_d1;
  logic signed [41:0] s3_pt;   // dT * C6
  logic signed [41:0] s3_po;   // C4 * dT
  logic signed [41:0] s3_ps;   // C3 * dT
  logic signed [49:0] s3_pdd;  // dT * dT

  always_ff @(posedge clk) begin
    s3_d1  <= s2_d1;
    s3_pt  <= 42'(s2_dt) * 42'($signed({1'b0, cal.temp_slope}));
    s3_po  <= 42'(s2_dt) * 42'($signed({1'b0, cal.off_temp_coef}));
    s3_ps  <= 42'(s2_dt) * 42'($signed({1'b0, cal.sens_temp_coef}));
    s3_pdd <= 50'(s2_dt) * 50'(s2_dt);
  end

  // Stage 4: first-order temperature, offset and sensitivity. Taking the upper
  // bits of a signed product is a floor shift. sh is TEMP - 2000, so the
  // second-order branch is simply its sign, and -15.00 C is sh < -3500.
  logic signed [18:0] sh_c;
  assign sh_c = $signed(s3_pt[41:23]);

  logic [23:0]        s4_d1;
  logic signed [18:0] s4_sh;
  logic signed [19:0] s4_temp;
  logic signed [35:0] s4_off;
  logic signed [35:0] s4_sens;
  logic [18:0]        s4_t2;
  logic               s4_low;
  logic               s4_vlow;

  always_ff @(posedge clk) begin
    s4_d1   <= s3_d1;
    s4_sh   <= sh_c;
    s4_temp <= 20'(sh_c) + 20'(TEMP_BASE);
    s4_off  <= 36'($signed({1'b0, cal.off_coef, 16'd0})) + 36'($signed(s3_po[41:7]));
    s4_sens <= 36'($signed({1'b0, cal.sens_coef, 15'd0})) + 36'($signed(s3_ps[41:8]));
    s4_t2   <= s3_pdd[49:31];
    s4_low  <= sh_c < 19'sd0;
    s4_vlow <= 20'(sh_c) < -20'(VERY_LOW_DELTA);
  end

  // Stage 5: the squares for the second-order terms. vl is TEMP + 1500.
  logic signed [19:0] vl_c;
  assign vl_c = 20'(s4_sh) + 20'(VERY_LOW_DELTA);

  logic [23:0]        s5_d1;
  logic signed [19:0] s5_temp;
  logic signed [35:0] s5_off;
  logic signed [35:0] s5_sens;
  logic [18:0]        s5_t2;
  logic               s5_low;
  logic               s5_vlow;
  logic signed [37:0] s5_losq;
  logic signed [39:0] s5_vsq;

  always_ff @(posedge clk) begin
    s5_d1   <= s4_d1;
    s5_temp <= s4_temp;
    s5_off  <= s4_off;
    s5_sens <= s4_sens;
    s5_t2   <= s4_t2;
    s5_low  <= s4_low;
    s5_vlow <= s4_vlow;
    s5_losq <= 38'(s4_sh) * 38'(s4_sh);
    s5_vsq  <= 40'(vl_c) * 40'(vl_c);
  end

  // Stage 6: OFF2, SENS2 and the corrected temperature. The squares are never
  // negative, so the halving and quartering shifts are plain.
  logic signed [41:0] sq5_c;
  logic signed [41:0] voff_c;
  logic signed [41:0] vsens_c;
  logic signed [41:0] off2_c;
  logic signed [41:0] sens2_c;

  always_comb begin
    sq5_c   = 42'(s5_losq) * 42'sd5;
    voff_c  = 42'(s5_vsq) * 42'sd7;
    vsens_c = (42'(s5_vsq) * 42'sd11) >>> 1;
    off2_c  = (sq5_c >>> 1) + (s5_vlow ? voff_c : 42'sd0);
    sens2_c = (sq5_c >>> 2) + (s5_vlow ? vsens_c : 42'sd0);
  end

  logic [23:0]        s6_d1;
  logic signed [20:0] s6_temp;
  logic signed [35:0] s6_off;
  logic signed [35:0] s6_sens;
  logic signed [41:0] s6_off2;
  logic signed [41:0] s6_sens2;

  always_ff @(posedge clk) begin
    s6_d1    <= s5_d1;
    s6_off   <= s5_off;
    s6_sens  <= s5_sens;
    s6_temp  <= 21'(s5_temp) - (s5_low ? $signed({2'b00, s5_t2}) : 21'sd0);
    s6_off2  <= s5_low ? off2_c : 42'sd0;
    s6_sens2 <= s5_low ? sens2_c : 42'sd0;
  end

  // Stage 7: final offset and sensitivity.
  logic [23:0]        s7_d1;
  logic signed [20:0] s7_temp;
  logic signed [42:0] s7_off;
  logic signed [42:0] s7_sens;

  always_ff @(posedge clk) begin
    s7_d1   <= s6_d1;
    s7_temp <= s6_temp;
    s7_off  <= 43'(s6_off) - 43'(s6_off2);
    s7_sens <= 43'(s6_sens) - 43'(s6_sens2);
  end

  // Stage 8: D1 * SENS as two partial products, the low 21 bits of SENS taken
  // unsigned and the upper 22 bits signed.
  logic signed [20:0] s8_temp;
  logic signed [42:0] s8_off;
  logic [44:0]        s8_plo;
  logic signed [46:0] s8_phi;

  always_ff @(posedge clk) begin
    s8_temp <= s7_temp;
    s8_off  <= s7_off;
    s8_plo  <= 45'(s7_d1) * 45'(s7_sens[20:0]);
    s8_phi  <= 47'($signed({1'b0, s7_d1})) * 47'($signed(s7_sens[42:21]));
  end

  // Stage 9: join the partial products.
  logic signed [20:0] s9_temp;
  logic signed [42:0] s9_off;
  logic signed [67:0] s9_prod;

  always_ff @(posedge clk) begin
    s9_temp <= s8_temp;
    s9_off  <= s8_off;
    s9_prod <= (68'(s8_phi) <<< 21) + $signed({23'd0, s8_plo});
  end

  // Stage 10: (D1 * SENS >> 21) - OFF.
  logic signed [20:0] s10_temp;
  logic signed [47:0] s10_x;

  always_ff @(posedge clk) begin
    s10_temp <= s9_temp;
    s10_x    <= 48'($signed(s9_prod[67:21])) - 48'(s9_off);
  end

  // Output register: the final shift by 15 and saturation to 32 bits. The
  // temperature stays well inside the 32-bit range and is only sign extended.
  always_ff @(posedge clk) begin
    result.temperature <= 32'(s10_temp);
    result.pressure    <= sat32($signed(s10_x[47:15]));
  end

endmodule

FILE: src/bpc_checker.sv
// Port-level checker for the compensation core, bound to the top level.
// Depends on bpc_pkg for the pipeline latency.
module bpc_checker
  import bpc_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // Reset empties the pipeline: no strobe in the cycle after it.
  a_reset_clears: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  // Every taken beat produces its own result strobe at the end of the pipeline.
  a_beat_to_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted beat lost in the pipeline");

  // No result strobe without a matching beat taken at the pipeline's input.
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result strobe without a matching beat");

  // Beats are refused only while reset is held.
  a_busy_only_in_reset: assert property (@(posedge clk) busy |-> rst)
    else $error("busy outside reset");

endmodule

bind barometric_pressure_compensation_core bpc_checker u_bpc_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

FILE: verif/tb_barometric_pressure_compensation_core.sv
// Self-checking testbench for barometric_pressure_compensation_core: drives sample beats
// and calibration writes, and checks every result against a behavioral predictor.
// Depends on bpc_pkg and the core RTL only.
module tb_barometric_pressure_compensation_core;
  import bpc_pkg::*;

  // Indexes past the last calibration word. The core must drop writes to them.
  localparam logic [REG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [REG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic [23:0] RAW_MAX = 24'hFF_FFFF;
  localparam logic [15:0] CAL_MAX = 16'hFFFF;

  // Random traffic is split into phases, each with its own calibration and gap rate.
  localparam int RANDOM_PHASES   = 14;
  localparam int BEATS_PER_PHASE = 125;

  // Temperature band that a sample falls in, used only for the coverage summary.
  typedef enum int {BAND_NORMAL, BAND_COLD, BAND_VERY_COLD} band_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  in_t  sample;
  logic done;
  out_t result;
  logic                   wr_en;
  logic [REG_INDEX_W-1:0] wr_index;
  logic [REG_DATA_W-1:0]  wr_data;

  // Our copy of the calibration words, updated whenever the core takes a write.
  cal_t cal_shadow;

  // Compensated readings the core still owes us, oldest first.
  out_t reading_q[$];

  int fail_count      = 0;
  int beats_sent      = 0;
  int readings_seen   = 0;
  int cal_settings    = 0;
  int cold_beats      = 0;
  int very_cold_beats = 0;

  // Percentage of beats that are preceded by an idle gap on the input side.
  int gap_pct = 0;

  barometric_pressure_compensation_core DUT (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .sample   (sample),
    .done     (done),
    .result   (result),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Clamp a wide signed value to the signed 32-bit range of the result fields.
  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fff_ffff;
    end
    if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // Compensated temperature and pressure for one raw pair under the current
  // calibration. Everything is carried in 64-bit signed arithmetic, which holds
  // every intermediate exactly; >>> on a signed value rounds toward minus
  // infinity, which is what the compensation formulas call for.
  function automatic out_t compensate(input in_t s, output band_t band);
    longint d1, d2, c1, c2, c3, c4, c5, c6;
    longint dt, temp, off, sens, t2, below, sq, off2, sens2, far, far_sq, pres;
    out_t r;
    d1 = s.raw_pressure;
    d2 = s.raw_temperature;
    c1 = cal_shadow.sens_coef;
    c2 = cal_shadow.off_coef;
    c3 = cal_shadow.sens_temp_coef;
    c4 = cal_shadow.off_temp_coef;
    c5 = cal_shadow.ref_temp;
    c6 = cal_shadow.temp_slope;

    // The difference is signed: a reading under the reference goes negative.
    dt   = d2 - c5 * 256;
    temp = TEMP_BASE + ((dt * c6) >>> 23);
    off  = c2 * 65536 + ((c4 * dt) >>> 7);
    sens = c1 * 32768 + ((c3 * dt) >>> 8);
    band = BAND_NORMAL;

    // Second-order correction below 20.00 C, with an extra term below -15.00 C.
    if (temp < TEMP_BASE) begin
      band  = BAND_COLD;
      t2    = (dt * dt) >>> 31;
      below = temp - TEMP_BASE;
      sq    = 5 * below * below;
      off2  = sq >>> 1;
      sens2 = sq >>> 2;
      if (temp < TEMP_BASE - VERY_LOW_DELTA) begin
        band   = BAND_VERY_COLD;
        far    = temp - (TEMP_BASE - VERY_LOW_DELTA);
        far_sq = far * far;
        off2   = off2 + 7 * far_sq;
        sens2  = sens2 + ((11 * far_sq) >>> 1);
      end
      temp = temp - t2;
      off  = off - off2;
      sens = sens - sens2;
    end

    pres = (((d1 * sens) >>> 21) - off) >>> 15;
    r.temperature = clamp32(temp);
    r.pressure    = clamp32(pres);
    return r;
  endfunction

  // Idle gap before a beat, for gap_pct percent of beats: mostly short, rarely long.
  function automatic int pick_gap();
    if ($urandom_range(0, 99) >= gap_pct) begin
      return 0;
    end
    if ($urandom_range(0, 9) != 0) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Raw temperature count. Most draws sit at a random distance from the
  // reference point C5*256, so that small and large differences of both signs
  // come up often and all three temperature bands get exercised.
  function automatic logic [23:0] pick_raw_temperature();
    longint center, v;
    int     k;
    if ($urandom_range(0, 3) == 0) begin
      return 24'($urandom_range(0, RAW_MAX));
    end
    center = longint'(cal_shadow.ref_temp) << 8;
    k      = $urandom_range(0, 23);
    v      = center + longint'($urandom_range(0, 2 ** (k + 1))) - longint'(2 ** k);
    if (v < 0) begin
      v = 0;
    end else if (v > RAW_MAX) begin
      v = RAW_MAX;
    end
    return v[23:0];
  endfunction

  // Raw pressure count: full range, with the two extremes showing up often.
  function automatic logic [23:0] pick_raw_pressure();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return RAW_MAX;
      default: return 24'($urandom_range(0, RAW_MAX));
    endcase
  endfunction

  // One calibration word, biased toward its extremes.
  function automatic logic [15:0] pick_cal_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return CAL_MAX;
      default: return 16'($urandom_range(0, CAL_MAX));
    endcase
  endfunction

  // Send one sample beat. Start is raised at a falling edge and the beat counts
  // as taken at the first rising edge that sees busy low. Start stays high
  // afterward, so back-to-back calls give one beat per cycle; a gap or a
  // settle lowers it.
  task automatic send_sample(input logic [23:0] d1, input logic [23:0] d2);
    in_t   s;
    band_t band;
    int    gap;
    s.raw_pressure    = d1;
    s.raw_temperature = d2;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start  = 1'b1;
    sample = s;
    @(posedge clk);
    while (busy !== 1'b0) begin
      @(posedge clk);
    end
    reading_q.push_back(compensate(s, band));
    beats_sent++;
    if (band != BAND_NORMAL) begin
      cold_beats++;
    end
    if (band == BAND_VERY_COLD) begin
      very_cold_beats++;
    end
  endtask

  // Drop start and wait until every owed result has come back. Each beat
  // makes exactly one result, so an empty queue means the pipeline is empty
  // and the calibration may be changed.
  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (reading_q.size() != 0) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  // Register write: one cycle of wr_en. Our copy follows the write at the
  // same edge at which the core takes it; spare indexes change nothing.
  task automatic write_cal(input logic [REG_INDEX_W-1:0] idx,
                           input logic [REG_DATA_W-1:0] value);
    @(negedge clk);
    wr_en    = 1'b1;
    wr_index = idx;
    wr_data  = value;
    @(posedge clk);
    case (idx)
      REG_SENS_COEF:      cal_shadow.sens_coef      = value;
      REG_OFF_COEF:       cal_shadow.off_coef       = value;
      REG_SENS_TEMP_COEF: cal_shadow.sens_temp_coef = value;
      REG_OFF_TEMP_COEF:  cal_shadow.off_temp_coef  = value;
      REG_REF_TEMP:       cal_shadow.ref_temp       = value;
      REG_TEMP_SLOPE:     cal_shadow.temp_slope     = value;
      default: ;
    endcase
    @(negedge clk);
    wr_en = 1'b0;
  endtask

  task automatic load_cal(input cal_t c);
    write_cal(REG_SENS_COEF, c.sens_coef);
    write_cal(REG_OFF_COEF, c.off_coef);
    write_cal(REG_SENS_TEMP_COEF, c.sens_temp_coef);
    write_cal(REG_OFF_TEMP_COEF, c.off_temp_coef);
    write_cal(REG_REF_TEMP, c.ref_temp);
    write_cal(REG_TEMP_SLOPE, c.temp_slope);
    cal_settings++;
  endtask

  // With every calibration word still at its reset value of zero, the core
  // must report 20.00 C and 0 Pa whatever the raw counts are.
  task automatic test_reset_state();
    gap_pct = 0;
    send_sample(RAW_MAX, RAW_MAX);
    send_sample('0, '0);
    settle();
  endtask

  // Writes to the two spare indexes must leave the calibration untouched.
  task automatic test_spare_indexes();
    write_cal(REG_SPARE_LO, CAL_MAX);
    write_cal(REG_SPARE_HI, 16'h5A5A);
    send_sample(24'h8A_A21A, 24'h82_C13E);
    settle();
  endtask

  // A typical factory calibration, with raw temperatures chosen to land just
  // above the reference point, exactly on it, just under it, in the cold
  // band, deep in the very cold band and at both ends of the raw range.
  task automatic test_temperature_bands();
    cal_t c;
    c.sens_coef      = 16'd40127;
    c.off_coef       = 16'd36924;
    c.sens_temp_coef = 16'd23317;
    c.off_temp_coef  = 16'd23282;
    c.ref_temp       = 16'd33464;
    c.temp_slope     = 16'd28312;
    load_cal(c);
    gap_pct = 30;
    send_sample(24'd9085466, 24'd8569150);   // just above 20.00 C
    send_sample(24'd9085466, 24'd8566784);   // reading equals the reference
    send_sample(24'd9085466, 24'd8566783);   // one count under the reference
    send_sample(24'd9085466, 24'd8000000);   // cold but above -15.00 C
    send_sample(24'd9085466, 24'd6566784);   // below -15.00 C
    send_sample(RAW_MAX, '0);                // coldest reading, largest raw pressure count
    send_sample('0, RAW_MAX);                // hottest reading, zero raw pressure count
    send_sample(RAW_MAX, RAW_MAX);
    send_sample('0, '0);
    settle();
  endtask

  // Every calibration word at its maximum, against the corners of the raw range.
  task automatic test_cal_extremes();
    cal_t c;
    c = '1;
    load_cal(c);
    gap_pct = 0;
    send_sample('0, '0);
    send_sample('0, RAW_MAX);
    send_sample(RAW_MAX, '0);
    send_sample(RAW_MAX, RAW_MAX);
    send_sample(24'h55_5555, 24'hAA_AAAA);
    settle();
  endtask

  // Bulk random traffic. Each phase loads a fresh random calibration while
  // the core is idle and then streams beats at its own gap rate, from
  // back-to-back bursts to sparse traffic.
  task automatic test_random_traffic();
    cal_t c;
    int   phase, n;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      c.sens_coef      = pick_cal_word();
      c.off_coef       = pick_cal_word();
      c.sens_temp_coef = pick_cal_word();
      c.off_temp_coef  = pick_cal_word();
      c.ref_temp       = pick_cal_word();
      c.temp_slope     = pick_cal_word();
      load_cal(c);
      case (phase % 4)
        0:       gap_pct = 0;
        1:       gap_pct = 15;
        2:       gap_pct = 50;
        default: gap_pct = 85;
      endcase
      for (n = 0; n < BEATS_PER_PHASE; n++) begin
        send_sample(pick_raw_pressure(), pick_raw_temperature());
      end
      settle();
    end
  endtask

  // Result checker. Results cannot be held off, so every cycle with done high
  // carries a result that must match the oldest reading still owed. Values
  // are sampled at the rising edge, before the core updates its outputs.
  always @(posedge clk) begin : check_results
    out_t want;
    if (rst === 1'b0) begin
      if (done === 1'b1) begin
        if (reading_q.size() == 0) begin
          $error("Result beat with nothing owed: temperature %0d, pressure %0d",
                 $signed(result.temperature), $signed(result.pressure));
          fail_count++;
        end else begin
          want = reading_q.pop_front();
          readings_seen++;
          if (result.temperature !== want.temperature) begin
            $error("temperature: expected %0d, actual %0d",
                   $signed(want.temperature), $signed(result.temperature));
            fail_count++;
          end
          if (result.pressure !== want.pressure) begin
            $error("pressure: expected %0d, actual %0d",
                   $signed(want.pressure), $signed(result.pressure));
            fail_count++;
          end
        end
      end else if (done !== 1'b0) begin
        $error("done is unknown after reset");
        fail_count++;
      end
    end
  end

  // Main sequence: one reset, the directed checks, then the random traffic.
  initial begin : run_tests
    int n;
    rst        = 1'b1;
    start      = 1'b0;
    sample     = '0;
    wr_en      = 1'b0;
    wr_index   = '0;
    wr_data    = '0;
    cal_shadow = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_spare_indexes();
    test_temperature_bands();
    test_cal_extremes();
    test_random_traffic();

    // Give any stray result time to show up, then insist nothing is owed.
    @(negedge clk);
    start = 1'b0;
    for (n = 0; n < 20 * LATENCY && reading_q.size() != 0; n++) begin
      @(posedge clk);
    end
    repeat (LATENCY + 8) @(posedge clk);
    if (reading_q.size() != 0) begin
      $error("%0d readings never came back", reading_q.size());
      fail_count++;
    end

    $display("Checked %0d of %0d sample beats over %0d calibration settings.",
             readings_seen, beats_sent, cal_settings);
    $display("%0d beats took the second-order path, %0d of them below -15.00 C.",
             cold_beats, very_cold_beats);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: set far beyond the slowest correct run, even with every beat
  // taking its longest gap.
  initial begin : watchdog
    #2000000;
    $display("Timed out with %0d readings still owed", reading_q.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: barometric_pressure_compensation_core.f
src/bpc_pkg.sv
src/bpc_cal_regs.sv
src/barometric_pressure_compensation_core.sv
src/bpc_checker.sv
verif/tb_barometric_pressure_compensation_core.sv
